// ----- design/world_to_screen_projection_defines.svh -----
// assertion macros shared by the projection block
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/wts_pkg.sv -----
`timescale 1ns / 1ps

package wts_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 14;
  localparam int OUT_W     = 30;

  // accumulator holds four shifted 32x32 products
  localparam int ACC_W = 2 * DATA_W - FRAC_BITS + 2;
  // scale factor (size << FRAC_BITS) and divider remainder
  localparam int M_W   = DIM_W + FRAC_BITS;
  localparam int K_W   = $clog2(M_W);
  localparam int REM_W = ACC_W + 2;

  // largest rejected w, floor of 0.01 in fixed point
  localparam int EPS = (1 << FRAC_BITS) / 100;

  // configuration register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_VIEW_READY    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X      = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Z      = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);

  // input modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  // point minus origin, clamped to 32 bits
  function automatic logic signed [DATA_W-1:0] sub_sat(
    input logic signed [DATA_W-1:0] p,
    input logic signed [DATA_W-1:0] o
  );
    logic signed [DATA_W:0] d;
    d = {p[DATA_W-1], p} - {o[DATA_W-1], o};
    if (d[DATA_W] != d[DATA_W-1]) begin
      sub_sat = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sub_sat = d[DATA_W-1:0];
    end
  endfunction

  // accumulator clamped to 32 bits
  function automatic logic signed [DATA_W-1:0] acc_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (a > hi) begin
      acc_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (a < lo) begin
      acc_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      acc_sat = a[DATA_W-1:0];
    end
  endfunction

endpackage

// ----- design/world_to_screen_projection.sv -----
`timescale 1ns / 1ps
// channel  | handshake          | payload
// in       | in_valid/in_ready  | mode matrix_select entry_index entry_value pos_x pos_y pos_z
// out      | out_valid/out_ready| visible screen_x screen_y
// config   | apb psel/penable   | paddr pwdata prdata, pready tied high
//
// a load word is stored without leaving idle; a visible point runs through every sequencer
// state, a rejected one skips the divisions and a not-ready one goes straight to done
// the work is done by one shared 32x32 multiply-accumulate (24 products) and one
// shared subtractor running two 30-step restoring divisions
// rst is synchronous: config returns to its reset values and matrix entries read as zero
// in_ready is low during reset and while a point is in work; a finished word waits in the
// output register while the next input word is taken

module world_to_screen_projection (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic                            matrix_select,
  input  logic [3:0]                      entry_index,
  input  logic signed [wts_pkg::DATA_W-1:0] entry_value,
  input  logic signed [wts_pkg::DATA_W-1:0] pos_x,
  input  logic signed [wts_pkg::DATA_W-1:0] pos_y,
  input  logic signed [wts_pkg::DATA_W-1:0] pos_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            visible,
  output logic [wts_pkg::OUT_W-1:0]       screen_x,
  output logic [wts_pkg::OUT_W-1:0]       screen_y,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wts_pkg::ADDR_W-1:0]      paddr,
  input  logic [wts_pkg::DATA_W-1:0]      pwdata,
  output logic [wts_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import wts_pkg::*;
  `include "world_to_screen_projection_defines.svh"

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_REL    = 11'b00000000010,
    S_VINIT  = 11'b00000000100,
    S_VMUL   = 11'b00000001000,
    S_VACC   = 11'b00000010000,
    S_PMUL   = 11'b00000100000,
    S_PACC   = 11'b00001000000,
    S_CHECK  = 11'b00010000000,
    S_DSHIFT = 11'b00100000000,
    S_DSUB   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // config registers
  logic                     view_ready;
  logic signed [DATA_W-1:0] origin_x, origin_y, origin_z;
  logic [DIM_W-1:0]         screen_width, screen_height;

  // matrix store, view entries in the low half
  logic signed [DATA_W-1:0] ent [32];
  logic [31:0]              ent_vld;

  // working registers
  logic signed [DATA_W-1:0] px, py, pz;
  logic signed [DATA_W-1:0] rel [3];
  logic signed [DATA_W-1:0] vw [4];
  logic [1:0]               row, col;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, cx, cy, cw;
  logic [REM_W-1:0]         a_op, b_op, rem;
  logic [M_W-1:0]           q;
  logic [K_W-1:0]           k;
  logic                     dsel;
  logic                     res_vis;
  logic [OUT_W-1:0]         res_x, res_y;

  // combinational
  logic [4:0]               mat_addr;
  logic signed [DATA_W-1:0] mat_rd, vec_op;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [M_W-1:0]           m_bits;
  logic [REM_W-1:0]         rem_sh, sub_src, sub_res;
  logic                     sub_ge;
  logic [M_W-1:0]           q_fin;
  logic                     reject;
  logic                     cfg_wr;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[4:2])
      REG_VIEW_READY:    prdata = {{(DATA_W-1){1'b0}}, view_ready};
      REG_ORIGIN_X:      prdata = origin_x;
      REG_ORIGIN_Y:      prdata = origin_y;
      REG_ORIGIN_Z:      prdata = origin_z;
      REG_SCREEN_WIDTH:  prdata = DATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_ready    <= 1'b0;
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_VIEW_READY:    view_ready    <= pwdata[0];
        REG_ORIGIN_X:      origin_x      <= pwdata;
        REG_ORIGIN_Y:      origin_y      <= pwdata;
        REG_ORIGIN_Z:      origin_z      <= pwdata;
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
        default:           ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  // matrix read port: translation column in VINIT, column col otherwise
  assign mat_addr = {(state == S_PMUL), (state == S_VINIT) ? 2'b11 : col, row};
  assign mat_rd   = ent_vld[mat_addr] ? ent[mat_addr] : '0;

  always_comb begin
    if (state == S_PMUL) begin
      vec_op = vw[col];
    end else begin
      case (col)
        2'd0:    vec_op = rel[0];
        2'd1:    vec_op = rel[1];
        default: vec_op = rel[2];
      endcase
    end
  end

  // accumulate the floor-shifted product
  assign acc_sum = acc + ACC_W'(prod >>> FRAC_BITS);

  // visibility test
  assign reject = (cw <= ACC_W'(EPS)) || (cx > cw) || (-cx > cw) || (cy > cw) || (-cy > cw);

  // shared divider step
  assign m_bits  = dsel ? {screen_height, {FRAC_BITS{1'b0}}} : {screen_width, {FRAC_BITS{1'b0}}};
  assign rem_sh  = (rem << 1) + (m_bits[k] ? a_op : '0);
  assign sub_src = (state == S_DSHIFT) ? rem_sh : rem;
  assign sub_ge  = (sub_src >= b_op);
  assign sub_res = sub_ge ? sub_src - b_op : sub_src;
  assign q_fin   = q + M_W'(sub_ge);

  // matrix store valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (in_valid && in_ready && mode == MODE_LOAD) begin
      ent_vld[{matrix_select, entry_index}] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && mode == MODE_LOAD) begin
      ent[{matrix_select, entry_index}] <= entry_value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && mode == MODE_PROJECT) begin
            px <= pos_x;
            py <= pos_y;
            pz <= pos_z;
            res_vis <= 1'b0;
            res_x   <= '0;
            res_y   <= '0;
            state   <= view_ready ? S_REL : S_DONE;
          end
        end
        S_REL: begin
          rel[0] <= sub_sat(px, origin_x);
          rel[1] <= sub_sat(py, origin_y);
          rel[2] <= sub_sat(pz, origin_z);
          row    <= 2'd0;
          state  <= S_VINIT;
        end
        S_VINIT: begin
          acc   <= ACC_W'(mat_rd);
          col   <= 2'd0;
          state <= S_VMUL;
        end
        S_VMUL: begin
          prod  <= mat_rd * vec_op;
          state <= S_VACC;
        end
        S_VACC: begin
          acc <= acc_sum;
          if (col == 2'd2) begin
            vw[row] <= acc_sat(acc_sum);
            if (row == 2'd3) begin
              row   <= 2'd0;
              col   <= 2'd0;
              acc   <= '0;
              state <= S_PMUL;
            end else begin
              row   <= row + 2'd1;
              state <= S_VINIT;
            end
          end else begin
            col   <= col + 2'd1;
            state <= S_VMUL;
          end
        end
        S_PMUL: begin
          prod  <= mat_rd * vec_op;
          state <= S_PACC;
        end
        S_PACC: begin
          if (col == 2'd3) begin
            acc <= '0;
            col <= 2'd0;
            // clip z is never used
            case (row)
              2'd0: begin
                cx    <= acc_sum;
                row   <= 2'd1;
                state <= S_PMUL;
              end
              2'd1: begin
                cy    <= acc_sum;
                row   <= 2'd3;
                state <= S_PMUL;
              end
              default: begin
                cw    <= acc_sum;
                state <= S_CHECK;
              end
            endcase
          end else begin
            acc   <= acc_sum;
            col   <= col + 2'd1;
            state <= S_PMUL;
          end
        end
        S_CHECK: begin
          if (reject) begin
            state <= S_DONE;
          end else begin
            a_op  <= REM_W'(cx) + REM_W'(cw);
            b_op  <= REM_W'(cw) << 1;
            rem   <= '0;
            q     <= '0;
            k     <= K_W'(M_W - 1);
            dsel  <= 1'b0;
            state <= S_DSHIFT;
          end
        end
        S_DSHIFT: begin
          rem   <= sub_res;
          q     <= {q[M_W-2:0], sub_ge};
          state <= S_DSUB;
        end
        S_DSUB: begin
          if (k == '0) begin
            if (!dsel) begin
              res_x <= OUT_W'(q_fin);
              a_op  <= REM_W'(cw) - REM_W'(cy);
              rem   <= '0;
              q     <= '0;
              k     <= K_W'(M_W - 1);
              dsel  <= 1'b1;
              state <= S_DSHIFT;
            end else begin
              res_y   <= OUT_W'(q_fin);
              res_vis <= 1'b1;
              state   <= S_DONE;
            end
          end else begin
            rem   <= sub_res;
            q     <= q_fin;
            k     <= k - K_W'(1);
            state <= S_DSHIFT;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      visible  <= res_vis;
      screen_x <= res_x;
      screen_y <= res_y;
    end
  end

  // checks
  `WTS_ASSERT_NOW(a_hidden_zero, out_valid && !visible, screen_x == '0 && screen_y == '0, "hidden word carries coordinates")
  `WTS_ASSERT_NOW(a_visible_ready, out_valid && visible, view_ready, "visible word without camera data")
  `WTS_ASSERT_NOW(a_rem_bound, state == S_DSHIFT, rem < b_op, "divider remainder out of range")
  `WTS_ASSERT_NEXT(a_busy, in_valid && in_ready && mode == MODE_PROJECT, !in_ready, "input taken during projection")

endmodule
